>>> hdl/udq_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the unique key deque.
package udq_pkg;

  localparam int DEPTH     = 16;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int KEY_W     = 32;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;
  localparam int ENTRY_W   = 5;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 40;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH      = 2'd0,
    ACT_POP_FRONT = 2'd1,
    ACT_POP_BACK  = 2'd2
  } udq_action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } udq_status_e;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the input word
    logic scan;    // walk the store for a duplicate
    logic pop_rd;  // read the entry a pop removes
    logic finish;  // commit and load the output register
  } udq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic scan_done;
    logic out_free;
  } udq_stat_t;

endpackage

>>> hdl/udq_ctrl.sv
// Controller state machine sequencing accept, duplicate scan, pop read and commit.
module udq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         in_action_i,
  output logic               in_ready_o,
  input  udq_pkg::udq_stat_t stat_i,
  output udq_pkg::udq_cmd_t  cmd_o
);
  import udq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } udq_state_e;

  udq_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (in_action_i)
            ACT_PUSH:      state_d = S_SCAN;
            ACT_POP_FRONT,
            ACT_POP_BACK:  state_d = stat_i.empty ? S_DONE : S_READ;
            default:       state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) state_d = S_DONE;
      end
      S_READ: begin
        cmd_o.pop_rd = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/udq_dp.sv
// Datapath: key store memory, ring pointers, duplicate compare and output register.
module udq_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [udq_pkg::ACT_W-1:0]   in_action_i,
  input  logic [udq_pkg::KEY_W-1:0]   in_key_i,
  input  udq_pkg::udq_cmd_t           cmd_i,
  output udq_pkg::udq_stat_t          stat_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [udq_pkg::STAT_W-1:0]  out_status_o,
  output logic [udq_pkg::KEY_W-1:0]   out_removed_o,
  output logic [udq_pkg::ENTRY_W-1:0] out_count_o
);
  import udq_pkg::*;

  function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0]  off);
    logic [ADDR_W:0] sum;
    sum = (ADDR_W+1)'(base) + (ADDR_W+1)'(off);
    if (sum >= (ADDR_W+1)'(DEPTH)) sum = sum - (ADDR_W+1)'(DEPTH);
    return sum[ADDR_W-1:0];
  endfunction

  logic [KEY_W-1:0]  mem [DEPTH];

  logic [ADDR_W-1:0] front_q, front_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ACT_W-1:0]  act_q;
  logic [KEY_W-1:0]  key_q;
  logic [CNT_W-1:0]  scan_idx_q;
  logic              rd_vld_q;
  logic              dup_q;
  logic [KEY_W-1:0]  rdata_q;

  logic              scan_issue;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              full;
  logic [STAT_W-1:0] status_d;
  logic [KEY_W-1:0]  removed_d;

  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic [KEY_W-1:0]  out_removed_q;
  logic [ENTRY_W-1:0] out_count_q;

  assign full       = (cnt_q == CNT_W'(DEPTH));
  assign scan_issue = cmd_i.scan && (scan_idx_q < cnt_q);
  assign rd_en      = scan_issue || cmd_i.pop_rd;

  always_comb begin
    if (scan_issue) begin
      rd_addr = ring_add(front_q, scan_idx_q);
    end else if (act_q == ACT_POP_BACK) begin
      rd_addr = ring_add(front_q, cnt_q - CNT_W'(1));
    end else begin
      rd_addr = front_q;
    end
  end

  // commit of the captured word
  always_comb begin
    status_d  = ST_OK;
    removed_d = '0;
    cnt_d     = cnt_q;
    front_d   = front_q;
    wr_en     = 1'b0;
    wr_addr   = ring_add(front_q, cnt_q);
    case (act_q)
      ACT_PUSH: begin
        if (dup_q) begin
          status_d = ST_DUP;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          wr_en = cmd_i.finish;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          removed_d = rdata_q;
          front_d   = ring_add(front_q, CNT_W'(1));
          cnt_d     = cnt_q - CNT_W'(1);
        end
      end
      ACT_POP_BACK: begin
        if (cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          removed_d = rdata_q;
          cnt_d     = cnt_q - CNT_W'(1);
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= key_q;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= in_action_i;
      key_q <= in_key_i;
    end
    if (cmd_i.finish) begin
      out_status_q  <= status_d;
      out_removed_q <= removed_d;
      out_count_q   <= ENTRY_W'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      cnt_q       <= '0;
      scan_idx_q  <= '0;
      rd_vld_q    <= 1'b0;
      dup_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        scan_idx_q <= '0;
        rd_vld_q   <= 1'b0;
        dup_q      <= 1'b0;
      end else begin
        if (scan_issue) scan_idx_q <= scan_idx_q + CNT_W'(1);
        rd_vld_q <= scan_issue;
        // compare the entry read in the previous cycle
        if (rd_vld_q && (rdata_q == key_q)) dup_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        front_q <= front_d;
        cnt_q   <= cnt_d;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.empty     = (cnt_q == '0);
  assign stat_o.scan_done = (scan_idx_q == cnt_q) && !rd_vld_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_removed_o = out_removed_q;
  assign out_count_o   = out_count_q;

endmodule

>>> hdl/unique_key_deque.sv
// Top level of the unique key deque: stream ports, controller and datapath.
// Push: the key store is walked one entry per cycle through its registered read port, looking for
//   a duplicate before the commit; every stored entry is read, also when the store is full.
// Pop: accept, memory read, commit; a pop on an empty store and an unused action skip the memory read.
// One word in flight; the next word is accepted while a result waits in the output register.
// Reset empties the deque (front and count cleared); store contents stay undefined.
module unique_key_deque (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [udq_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,  // [31:0] key
  input  logic [udq_pkg::ACT_W-1:0]      s_axis_tuser_i,  // [1:0] action
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [udq_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,  // [31:0] removed_key, [36:32] entry_count
  output logic [udq_pkg::STAT_W-1:0]     m_axis_tuser_o   // [1:0] status
);
  import udq_pkg::*;

  udq_cmd_t          cmd;
  udq_stat_t         stat;
  logic [KEY_W-1:0]  removed_key;
  logic [ENTRY_W-1:0] entry_count;

  udq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_action_i (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  udq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_action_i   (s_axis_tuser_i),
    .in_key_i      (s_axis_tdata_i[KEY_W-1:0]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_status_o  (m_axis_tuser_o),
    .out_removed_o (removed_key),
    .out_count_o   (entry_count)
  );

  assign m_axis_tdata_o = {(M_TDATA_W - KEY_W - ENTRY_W)'(0), entry_count, removed_key};

  // one word at a time: after an accept the input side is closed
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while a word is in flight");

  // a commit always presents a result on the next cycle
  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> m_axis_tvalid_o)
    else $error("committed result not presented");

  // only a successful removal carries a key out
  a_removed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != ST_OK)) |-> (removed_key == '0))
    else $error("removed key nonzero on a failed request");

endmodule

>>> verif/unique_key_deque_tb.sv
// Self-checking testbench for the unique key deque: directed table, then random traffic.
module unique_key_deque_tb;
  import udq_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 700;
  localparam int TAIL_ITEMS   = 100;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int NUM_ROWS     = 15;

  typedef struct packed {
    udq_status_e        status;
    logic [KEY_W-1:0]   removed_key;
    logic [ENTRY_W-1:0] entry_count;
  } deque_result_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] key_step;
    logic [4:0]       reps;
    logic             literal_exp;  // use outcome below instead of the predictor
    deque_result_t    outcome;
  } stim_row_t;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i;   // [31:0] key
  logic [ACT_W-1:0]     s_axis_tuser_i;   // [1:0] action
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;   // [31:0] removed_key, [36:32] entry_count
  logic [STAT_W-1:0]    m_axis_tuser_o;   // [1:0] status

  // predictor state
  logic [KEY_W-1:0]  deque_keys [DEPTH];
  logic [ADDR_W-1:0] deque_front = '0;
  logic [CNT_W-1:0]  deque_count = '0;

  deque_result_t pending_results[$];
  int            mismatch_count = 0;
  bit            hold_request   = 1'b0;
  bit            quiet_tail     = 1'b0;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ACT_POP_FRONT, 32'h0000_0000, 32'h0, 5'd1, 1'b1, '{ST_EMPTY, 32'h0, 5'd0}},
    '{ACT_POP_BACK,  32'hFFFF_FFFF, 32'h0, 5'd1, 1'b1, '{ST_EMPTY, 32'h0, 5'd0}},
    '{ACT_UNUSED,    32'hA5A5_A5A5, 32'h0, 5'd1, 1'b1, '{ST_OK,    32'h0, 5'd0}},
    '{ACT_PUSH,      32'h8000_0000, 32'h0, 5'd1, 1'b1, '{ST_OK,    32'h0, 5'd1}},
    '{ACT_PUSH,      32'h7FFF_FFFF, 32'h0, 5'd1, 1'b1, '{ST_OK,    32'h0, 5'd2}},
    '{ACT_PUSH,      32'h8000_0000, 32'h0, 5'd1, 1'b1, '{ST_DUP,   32'h0, 5'd2}},
    '{ACT_POP_FRONT, 32'h0000_0000, 32'h0, 5'd1, 1'b1, '{ST_OK, 32'h8000_0000, 5'd1}},
    // fill to the brim with fifteen distinct keys
    '{ACT_PUSH,      32'h0000_0000, 32'h1111_1111, 5'd15, 1'b0, '0},
    '{ACT_PUSH,      32'h1234_5678, 32'h0, 5'd1, 1'b1, '{ST_FULL,  32'h0, 5'd16}},
    // duplicate wins over full
    '{ACT_PUSH,      32'h7FFF_FFFF, 32'h0, 5'd1, 1'b1, '{ST_DUP,   32'h0, 5'd16}},
    '{ACT_POP_BACK,  32'h0000_0000, 32'h0, 5'd1, 1'b0, '0},
    '{ACT_POP_FRONT, 32'h0000_0000, 32'h0, 5'd1, 1'b0, '0},
    '{ACT_PUSH,      32'hFFFF_FFFF, 32'h0, 5'd1, 1'b0, '0},
    '{ACT_UNUSED,    32'h5A5A_5A5A, 32'h0, 5'd1, 1'b0, '0},
    '{ACT_POP_BACK,  32'h0000_0000, 32'h0, 5'd1, 1'b0, '0}
  };

  unique_key_deque dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Apply one request to the predictor state and return the word it should produce.
  function automatic deque_result_t apply_request(logic [ACT_W-1:0] action,
                                                  logic [KEY_W-1:0] key);
    deque_result_t     res;
    logic [ADDR_W-1:0] slot;
    bit                hit;
    res = '{ST_OK, '0, '0};
    hit = 1'b0;
    case (action)
      ACT_PUSH: begin
        for (int i = 0; i < deque_count; i++) begin
          slot = ADDR_W'(deque_front + i);
          if (deque_keys[slot] == key) hit = 1'b1;
        end
        if (hit) begin
          res.status = ST_DUP;
        end else if (deque_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot = ADDR_W'(deque_front + deque_count);
          deque_keys[slot] = key;
          deque_count++;
        end
      end
      ACT_POP_FRONT: begin
        if (deque_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.removed_key = deque_keys[deque_front];
          deque_front++;
          deque_count--;
        end
      end
      ACT_POP_BACK: begin
        if (deque_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          slot = ADDR_W'(deque_front + deque_count - 1);
          res.removed_key = deque_keys[slot];
          deque_count--;
        end
      end
      default: ;
    endcase
    res.entry_count = deque_count[ENTRY_W-1:0];
    return res;
  endfunction

  // Offer one word, wait for the handshake, then queue its expected result.
  task automatic send_item(logic [ACT_W-1:0] action, logic [KEY_W-1:0] key,
                           logic literal_exp, deque_result_t outcome);
    deque_result_t predicted;
    if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= key;
    s_axis_tuser_i  <= action;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predicted = apply_request(action, key);
    pending_results.push_back(literal_exp ? outcome : predicted);
  endtask

  initial begin : stimulus
    int               r;
    int               n;
    int               mode_left;
    int               roll;
    traffic_mode_e    mode;
    stim_row_t        row;
    logic [ACT_W-1:0] action;
    logic [KEY_W-1:0] key;
    logic [ADDR_W-1:0] slot;
    mode_left = 0;
    mode = MODE_MIXED;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < NUM_ROWS; r++) begin
      row = directed_rows[r];
      for (n = 0; n < row.reps; n++)
        send_item(row.action, row.key + row.key_step * n, row.literal_exp, row.outcome);
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) hold_request = 1'b1;
      if (n == RANDOM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
      if (mode_left == 0) begin
        mode = traffic_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(10, 40);
      end
      mode_left--;

      roll = $urandom_range(0, 99);
      case (mode)
        MODE_FILL:  action = (roll < 75) ? ACT_PUSH : (roll < 88) ? ACT_POP_FRONT : ACT_POP_BACK;
        MODE_DRAIN: action = (roll < 25) ? ACT_PUSH : (roll < 62) ? ACT_POP_FRONT : ACT_POP_BACK;
        default:    action = (roll < 40) ? ACT_PUSH : (roll < 70) ? ACT_POP_FRONT : ACT_POP_BACK;
      endcase
      if ($urandom_range(0, 31) == 0) action = ACT_UNUSED;

      // bias keys toward stored ones and a small range so duplicates show up often
      roll = $urandom_range(0, 2);
      if (roll == 0 && deque_count != 0) begin
        slot = ADDR_W'(deque_front + $urandom_range(0, deque_count - 1));
        key = deque_keys[slot];
      end else if (roll == 1) begin
        key = $urandom_range(0, 40);
      end else begin
        key = $urandom;
      end
      send_item(action, key, 1'b0, '0);
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin : result_sink
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        // back-pressure long enough for the input side to stall
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    deque_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with no request outstanding");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser_o !== want.status) begin
          $error("status: expected %s, got %0d", want.status.name(), m_axis_tuser_o);
          mismatch_count++;
        end
        if (m_axis_tdata_o[31:0] !== want.removed_key) begin
          $error("removed_key: expected %h, got %h", want.removed_key, m_axis_tdata_o[31:0]);
          mismatch_count++;
        end
        if (m_axis_tdata_o[36:32] !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 m_axis_tdata_o[36:32]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
hdl/udq_pkg.sv
hdl/udq_ctrl.sv
hdl/udq_dp.sv
hdl/unique_key_deque.sv
verif/unique_key_deque_tb.sv
